// ----- hdl/tlpte_pkg.sv -----
`timescale 1ns / 1ps

package tlpte_pkg;

   // Size of the table pool and of the two levels.
   localparam int TABLE_SLOTS   = 16;
   localparam int DIR_ENTRIES   = 1024;
   localparam int TABLE_ENTRIES = 1024;
   localparam int POOL_ENTRIES  = TABLE_SLOTS * TABLE_ENTRIES;

   // Derived widths.
   localparam int IDX_W   = 10;
   localparam int FRAME_W = 20;
   localparam int OFFS_W  = 12;
   localparam int SLOT_W  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int NFS_W   = $clog2(TABLE_SLOTS + 1);
   localparam int ENT_AW  = $clog2(POOL_ENTRIES);
   localparam int DIR_W   = SLOT_W + 1;
   localparam int ENT_W   = FRAME_W + 1;

   // Command codes.
   localparam logic CMD_TRANSLATE = 1'b0;
   localparam logic CMD_MAP       = 1'b1;

   // Status codes.
   localparam logic [1:0] STATUS_DONE     = 2'd0;
   localparam logic [1:0] STATUS_UNMAPPED = 2'd1;
   localparam logic [1:0] STATUS_NO_SLOT  = 2'd2;

   typedef struct packed {
      logic        command;
      logic [31:0] virt_addr;
      logic [31:0] phys_addr;
      logic [22:0] map_size;
      logic        present_flag;
      logic        writable_flag;
      logic        user_flag;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] phys_out;
   } rsp_type;

endpackage

// ----- hdl/two_level_page_table_engine.sv -----
`timescale 1ns / 1ps

// Two-level page table engine. After reset the block runs a clearing pass over
// the directory and page entry memories, holding busy high. An item is taken
// when start is high and busy is low; its single result appears on rsp_data for
// one cycle with rsp_strobe and must be captured then, as the block cannot be
// stalled. A translate item keeps busy high while it reads the directory and
// then the page entry memory, and ends after the directory read when the
// directory entry is absent. A map item keeps busy high while it walks each page
// touched by the range, up to and including the page at which the pool runs dry
// if it does, and ends without touching the memories for a zero length; each page
// reads the directory and then writes the page entry, and the directory when a
// new table slot is taken. The next item may be started in the cycle that the
// result is shown.
module two_level_page_table_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tlpte_pkg::req_type req_data,
   output logic              rsp_strobe,
   output tlpte_pkg::rsp_type rsp_data
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_T_RD,
      ST_T_DIR,
      ST_T_ENT,
      ST_M_INIT,
      ST_M_RD,
      ST_M_CHK
   } state_type;

   state_type                         state_ff;
   logic [tlpte_pkg::ENT_AW-1:0]      clr_ff;
   logic [tlpte_pkg::NFS_W-1:0]       next_free_ff;
   logic [tlpte_pkg::FRAME_W-1:0]     page_ff;
   logic [tlpte_pkg::FRAME_W-1:0]     last_ff;
   logic [tlpte_pkg::FRAME_W-1:0]     frame_ff;
   logic [tlpte_pkg::OFFS_W-1:0]      offs_ff;
   logic [22:0]                       size_ff;
   logic                              pf_ff;
   logic                              rsp_strobe_ff;
   tlpte_pkg::rsp_type                rsp_ff;

   logic                              dir_we;
   logic [tlpte_pkg::IDX_W-1:0]       dir_wa;
   logic [tlpte_pkg::DIR_W-1:0]       dir_wd;
   logic [tlpte_pkg::DIR_W-1:0]       dir_q;
   logic                              ent_we;
   logic [tlpte_pkg::ENT_AW-1:0]      ent_wa;
   logic [tlpte_pkg::ENT_W-1:0]       ent_wd;
   logic [tlpte_pkg::ENT_AW-1:0]      ent_ra;
   logic [tlpte_pkg::ENT_W-1:0]       ent_q;

   logic                              dir_hit;
   logic [tlpte_pkg::SLOT_W-1:0]      dir_slot;
   logic                              pool_free;
   logic [tlpte_pkg::SLOT_W-1:0]      new_slot;
   logic [32:0]                       end_sum;
   logic [tlpte_pkg::FRAME_W-1:0]     last_pg;

   // Directory: present bit over the table slot number.
   tlpte_ram #(
      .DEPTH (tlpte_pkg::DIR_ENTRIES),
      .WIDTH (tlpte_pkg::DIR_W)
   ) u_dir_ram (
      .clock   (clock),
      .wr_en   (dir_we),
      .wr_addr (dir_wa),
      .wr_data (dir_wd),
      .rd_addr (page_ff[tlpte_pkg::FRAME_W-1:tlpte_pkg::IDX_W]),
      .rd_data (dir_q)
   );

   // Page entries of the whole pool: present bit over the frame number.
   tlpte_ram #(
      .DEPTH (tlpte_pkg::POOL_ENTRIES),
      .WIDTH (tlpte_pkg::ENT_W)
   ) u_ent_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (ent_wa),
      .wr_data (ent_wd),
      .rd_addr (ent_ra),
      .rd_data (ent_q)
   );

   // Directory lookup result and pool state.
   assign dir_hit   = dir_q[tlpte_pkg::SLOT_W];
   assign dir_slot  = dir_q[tlpte_pkg::SLOT_W-1:0];
   assign pool_free = (next_free_ff != tlpte_pkg::NFS_W'(tlpte_pkg::TABLE_SLOTS));
   assign new_slot  = tlpte_pkg::SLOT_W'(next_free_ff);
   assign ent_ra    = tlpte_pkg::ENT_AW'({dir_slot, page_ff[tlpte_pkg::IDX_W-1:0]});

   // Last page of a map range, clamped at the top of the address space.
   assign end_sum = {1'b0, page_ff, offs_ff} + 33'(size_ff) - 33'd1;
   assign last_pg = end_sum[32] ? {tlpte_pkg::FRAME_W{1'b1}} : end_sum[31:12];

   // Memory write control for the clearing pass and the map walk.
   always_comb begin
      dir_we = 1'b0;
      dir_wa = page_ff[tlpte_pkg::FRAME_W-1:tlpte_pkg::IDX_W];
      dir_wd = {1'b1, new_slot};
      ent_we = 1'b0;
      ent_wa = dir_hit ? ent_ra
                       : tlpte_pkg::ENT_AW'({new_slot, page_ff[tlpte_pkg::IDX_W-1:0]});
      ent_wd = {pf_ff, frame_ff};
      unique case (state_ff)
         ST_CLEAR: begin
            dir_we = 1'b1;
            dir_wa = clr_ff[tlpte_pkg::IDX_W-1:0];
            dir_wd = '0;
            ent_we = 1'b1;
            ent_wa = clr_ff;
            ent_wd = '0;
         end
         ST_M_CHK: begin
            if (dir_hit) begin
               ent_we = 1'b1;
            end else if (pool_free) begin
               dir_we = 1'b1;
               ent_we = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Sequencer: clearing pass, translate walk and map walk.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         next_free_ff  <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == tlpte_pkg::ENT_AW'(tlpte_pkg::POOL_ENTRIES - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (start) begin
                  page_ff  <= req_data.virt_addr[31:12];
                  offs_ff  <= req_data.virt_addr[11:0];
                  frame_ff <= req_data.phys_addr[31:12];
                  size_ff  <= req_data.map_size;
                  pf_ff    <= req_data.present_flag;
                  if (req_data.command == tlpte_pkg::CMD_MAP) begin
                     state_ff <= ST_M_INIT;
                  end else begin
                     state_ff <= ST_T_RD;
                  end
               end
            end
            ST_T_RD: begin
               state_ff <= ST_T_DIR;
            end
            ST_T_DIR: begin
               if (!dir_hit) begin
                  rsp_strobe_ff   <= 1'b1;
                  rsp_ff.status   <= tlpte_pkg::STATUS_UNMAPPED;
                  rsp_ff.phys_out <= '0;
                  state_ff        <= ST_IDLE;
               end else begin
                  state_ff <= ST_T_ENT;
               end
            end
            ST_T_ENT: begin
               rsp_strobe_ff <= 1'b1;
               state_ff      <= ST_IDLE;
               if (ent_q[tlpte_pkg::FRAME_W]) begin
                  rsp_ff.status   <= tlpte_pkg::STATUS_DONE;
                  rsp_ff.phys_out <= {ent_q[tlpte_pkg::FRAME_W-1:0], offs_ff};
               end else begin
                  rsp_ff.status   <= tlpte_pkg::STATUS_UNMAPPED;
                  rsp_ff.phys_out <= '0;
               end
            end
            ST_M_INIT: begin
               last_ff <= last_pg;
               if (size_ff == '0) begin
                  rsp_strobe_ff   <= 1'b1;
                  rsp_ff.status   <= tlpte_pkg::STATUS_DONE;
                  rsp_ff.phys_out <= '0;
                  state_ff        <= ST_IDLE;
               end else begin
                  state_ff <= ST_M_CHK;
               end
            end
            ST_M_RD: begin
               state_ff <= ST_M_CHK;
            end
            ST_M_CHK: begin
               if (dir_hit || pool_free) begin
                  if (!dir_hit) begin
                     next_free_ff <= next_free_ff + 1'b1;
                  end
                  if (page_ff == last_ff) begin
                     rsp_strobe_ff   <= 1'b1;
                     rsp_ff.status   <= tlpte_pkg::STATUS_DONE;
                     rsp_ff.phys_out <= '0;
                     state_ff        <= ST_IDLE;
                  end else begin
                     page_ff  <= page_ff + 1'b1;
                     frame_ff <= frame_ff + 1'b1;
                     state_ff <= ST_M_RD;
                  end
               end else begin
                  // Pool exhausted: pages written so far stay mapped.
                  rsp_strobe_ff   <= 1'b1;
                  rsp_ff.status   <= tlpte_pkg::STATUS_NO_SLOT;
                  rsp_ff.phys_out <= '0;
                  state_ff        <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ----- hdl/tlpte_ram.sv -----
`timescale 1ns / 1ps

module tlpte_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one read port; the read data is registered.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
   import tlpte_pkg::*;

   // One row of the directed part: the item, and its result where it is fixed by hand.
   typedef struct packed {
      req_type item;
      logic    has_want;
      rsp_type want;
   } walk_row_type;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   // Shadow page tables.
   bit                dir_valid [DIR_ENTRIES];
   logic [SLOT_W-1:0] dir_table [DIR_ENTRIES];
   bit                pte_valid [POOL_ENTRIES];
   logic [21:0]       pte_bits  [POOL_ENTRIES];
   int unsigned       tables_used = 0;

   // Results still owed by the block, oldest first.
   rsp_type     table_outcomes [$];
   int unsigned failures = 0;

   // Directory regions that hold a table, and recent mapped ranges to aim translates at.
   logic [9:0]  live_regions [$];
   logic [31:0] recent_starts [$];
   int unsigned recent_lengths [$];

   walk_row_type walk_table [24] = '{
      // Nothing is mapped after reset.
      '{'{CMD_TRANSLATE, 32'h0000_0000, 32'h0000_0000, 23'd0, 1'b0, 1'b0, 1'b0},
        1'b1, '{STATUS_UNMAPPED, 32'h0}},
      '{'{CMD_TRANSLATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 23'h40_0000, 1'b1, 1'b1, 1'b1},
        1'b1, '{STATUS_UNMAPPED, 32'h0}},
      // Low bits of the physical address are dropped from the frame.
      '{'{CMD_MAP, 32'h0000_0000, 32'h1234_5678, 23'd1, 1'b1, 1'b1, 1'b1},
        1'b1, '{STATUS_DONE, 32'h0}},
      '{'{CMD_TRANSLATE, 32'h0000_0ABC, 32'h0, 23'd0, 1'b0, 1'b0, 1'b0},
        1'b1, '{STATUS_DONE, 32'h1234_5ABC}},
      // A zero length maps nothing.
      '{'{CMD_MAP, 32'h0040_0000, 32'h0000_0000, 23'd0, 1'b1, 1'b1, 1'b1},
        1'b1, '{STATUS_DONE, 32'h0}},
      '{'{CMD_TRANSLATE, 32'h0040_0000, 32'h0, 23'd0, 1'b0, 1'b0, 1'b0},
        1'b1, '{STATUS_UNMAPPED, 32'h0}},
      // The largest range at the top of memory is cut at the last byte.
      '{'{CMD_MAP, 32'hFFFF_F000, 32'hFFFF_FFFF, 23'h40_0000, 1'b1, 1'b0, 1'b1},
        1'b1, '{STATUS_DONE, 32'h0}},
      '{'{CMD_TRANSLATE, 32'hFFFF_FFFF, 32'h0, 23'd0, 1'b0, 1'b0, 1'b0},
        1'b1, '{STATUS_DONE, 32'hFFFF_FFFF}},
      // An entry written with the present bit clear does not translate.
      '{'{CMD_MAP, 32'h0000_2000, 32'h0000_0000, 23'h1000, 1'b0, 1'b1, 1'b0},
        1'b1, '{STATUS_DONE, 32'h0}},
      '{'{CMD_TRANSLATE, 32'h0000_2FFF, 32'h0, 23'd0, 1'b0, 1'b0, 1'b0},
        1'b1, '{STATUS_UNMAPPED, 32'h0}},
      // A range across a directory boundary takes a second table.
      '{'{CMD_MAP, 32'h003F_F800, 32'hABCD_E000, 23'h1000, 1'b1, 1'b1, 1'b1},
        1'b1, '{STATUS_DONE, 32'h0}},
      '{'{CMD_TRANSLATE, 32'h0040_0123, 32'h0, 23'd0, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
      '{'{CMD_TRANSLATE, 32'h003F_F7FF, 32'h0, 23'd0, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
      // Largest unaligned range; the frame numbers wrap past the top.
      '{'{CMD_MAP, 32'h1234_5678, 32'hFFFF_F800, 23'h40_0000, 1'b1, 1'b1, 1'b0},
        1'b1, '{STATUS_DONE, 32'h0}},
      '{'{CMD_TRANSLATE, 32'h1274_5677, 32'h0, 23'd0, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
      '{'{CMD_TRANSLATE, 32'h1234_5000, 32'h0, 23'd0, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
      // Use up the pool two tables at a time.
      '{'{CMD_MAP, 32'h07FF_F000, 32'h0000_0000, 23'h2000, 1'b1, 1'b0, 1'b0},
        1'b1, '{STATUS_DONE, 32'h0}},
      '{'{CMD_MAP, 32'h0FFF_F000, 32'h8000_0000, 23'h2000, 1'b1, 1'b1, 1'b1},
        1'b1, '{STATUS_DONE, 32'h0}},
      '{'{CMD_MAP, 32'h3FFF_F000, 32'h0F0F_0000, 23'h2000, 1'b1, 1'b0, 1'b1},
        1'b1, '{STATUS_DONE, 32'h0}},
      '{'{CMD_MAP, 32'h7FFF_F000, 32'hF0F0_F000, 23'h2000, 1'b1, 1'b1, 1'b0},
        1'b1, '{STATUS_DONE, 32'h0}},
      '{'{CMD_MAP, 32'hBFFF_F000, 32'h2468_A000, 23'h2000, 1'b1, 1'b1, 1'b1},
        1'b1, '{STATUS_DONE, 32'h0}},
      // The pool runs dry on the second page; the first one stays mapped.
      '{'{CMD_MAP, 32'hEFFF_F000, 32'h5555_5000, 23'h2000, 1'b1, 1'b1, 1'b1},
        1'b1, '{STATUS_NO_SLOT, 32'h0}},
      '{'{CMD_TRANSLATE, 32'hEFFF_FABC, 32'h0, 23'd0, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
      '{'{CMD_TRANSLATE, 32'hF000_0000, 32'h0, 23'd0, 1'b0, 1'b0, 1'b0},
        1'b1, '{STATUS_UNMAPPED, 32'h0}}
   };

   two_level_page_table_engine dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #5 clock = ~clock;

   // Apply one item to the shadow tables and work out the result it gives.
   task automatic work_out_outcome(input req_type r, output rsp_type res);
      logic [9:0]  pd;
      logic [32:0] last_addr;
      logic [31:0] page_va;
      logic [31:0] frame_addr;
      int unsigned idx;
      int unsigned first_pg;
      int unsigned last_pg;
      int unsigned k;
      res = '{STATUS_DONE, 32'h0};
      if (r.command == CMD_TRANSLATE) begin
         pd = r.virt_addr[31:22];
         idx = dir_table[pd] * TABLE_ENTRIES + r.virt_addr[21:12];
         if (!dir_valid[pd] || !pte_valid[idx]) begin
            res.status = STATUS_UNMAPPED;
         end else begin
            res.phys_out = {pte_bits[idx][21:2], r.virt_addr[11:0]};
         end
      end else if (r.map_size != 0) begin
         // The range stops at the top of memory rather than wrapping.
         last_addr = {1'b0, r.virt_addr} + 33'(r.map_size) - 33'd1;
         if (last_addr[32]) begin
            last_addr = 33'h0_FFFF_FFFF;
         end
         first_pg = r.virt_addr[31:12];
         last_pg = last_addr[31:12];
         for (k = 0; k <= last_pg - first_pg; k++) begin
            page_va = (first_pg + k) << 12;
            frame_addr = r.phys_addr + (k << 12);
            pd = page_va[31:22];
            if (!dir_valid[pd]) begin
               if (tables_used >= TABLE_SLOTS) begin
                  res.status = STATUS_NO_SLOT;
                  break;
               end
               dir_valid[pd] = 1'b1;
               dir_table[pd] = tables_used[SLOT_W-1:0];
               for (int e = 0; e < TABLE_ENTRIES; e++) begin
                  pte_valid[tables_used * TABLE_ENTRIES + e] = 1'b0;
               end
               tables_used++;
            end
            idx = dir_table[pd] * TABLE_ENTRIES + page_va[21:12];
            pte_valid[idx] = r.present_flag;
            pte_bits[idx] = {frame_addr[31:12], r.writable_flag, r.user_flag};
         end
      end
   endtask

   // Draw a random item, mostly within the regions that hold a table.
   task automatic draw_item(output req_type r);
      int unsigned roll;
      int unsigned pick;
      r = '0;
      r.virt_addr = $urandom;
      r.phys_addr = $urandom;
      r.present_flag = ($urandom_range(0, 99) < 85);
      r.writable_flag = 1'($urandom_range(0, 1));
      r.user_flag = 1'($urandom_range(0, 1));
      r.map_size = 23'($urandom_range(1, 4194304));
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
         r.command = CMD_MAP;
         if ($urandom_range(0, 99) < 85) begin
            r.virt_addr[31:22] = live_regions[$urandom_range(0, live_regions.size() - 1)];
         end
         if ($urandom_range(0, 1) == 0) begin
            r.virt_addr[11:0] = '0;
         end
         // Most ranges are short; a few are near the largest allowed.
         roll = $urandom_range(0, 99);
         if (roll < 3) begin
            r.map_size = 23'($urandom_range(2097152, 4194304));
         end else if (roll < 5) begin
            r.map_size = '0;
         end else if (roll < 40) begin
            r.map_size = 23'($urandom_range(1, 4096));
         end else begin
            r.map_size = 23'($urandom_range(1, 65536));
         end
         if (r.map_size != 0 && r.present_flag) begin
            recent_starts.push_back(r.virt_addr);
            recent_lengths.push_back(r.map_size);
            if (recent_starts.size() > 64) begin
               void'(recent_starts.pop_front());
               void'(recent_lengths.pop_front());
            end
         end
      end else begin
         r.command = CMD_TRANSLATE;
         if (roll < 80 && recent_starts.size() != 0) begin
            pick = $urandom_range(0, recent_starts.size() - 1);
            r.virt_addr = recent_starts[pick] + $urandom_range(0, recent_lengths[pick] - 1);
         end else if (roll < 93) begin
            r.virt_addr[31:22] = live_regions[$urandom_range(0, live_regions.size() - 1)];
         end
      end
   endtask

   // Present an item and wait for the block to take it.
   task automatic send_item(input req_type r, input rsp_type want);
      @(negedge clock);
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy !== 1'b0);
      table_outcomes.push_back(want);
   endtask

   // Hold start low while leaving random data on the request port.
   task automatic hold_off(input int unsigned cycles);
      logic [95:0] noise;
      noise = {$urandom, $urandom, $urandom};
      @(negedge clock);
      start <= 1'b0;
      req_data <= noise[90:0];
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Stimulus: directed table first, then random items.
   initial begin : stimulus
      req_type     item;
      rsp_type     outcome;
      int unsigned n_random;
      bit          gaps_allowed;
      n_random = 1126;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (walk_table[i]) begin
         work_out_outcome(walk_table[i].item, outcome);
         if (walk_table[i].has_want) begin
            outcome = walk_table[i].want;
         end
         if ($urandom_range(0, 3) == 0) begin
            hold_off($urandom_range(1, 12));
         end
         send_item(walk_table[i].item, outcome);
      end

      for (int d = 0; d < DIR_ENTRIES; d++) begin
         if (dir_valid[d]) begin
            live_regions.push_back(10'(d));
         end
      end

      for (int unsigned n = 0; n < n_random; n++) begin
         // Now and then let the block drain completely before going on.
         if (n % 600 == 0) begin
            @(negedge clock);
            start <= 1'b0;
            while (table_outcomes.size() != 0) @(posedge clock);
         end
         gaps_allowed = ((n / 80) % 2 == 0) && (n + 150 < n_random);
         if (gaps_allowed && $urandom_range(0, 99) < 35) begin
            hold_off($urandom_range(1, 12));
         end
         draw_item(item);
         work_out_outcome(item, outcome);
         send_item(item, outcome);
      end

      @(negedge clock);
      start <= 1'b0;
      while (table_outcomes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (failures == 0 && table_outcomes.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Compare each result with the oldest one owed.
   always @(posedge clock) begin : check_outcomes
      rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (table_outcomes.size() == 0) begin
            $display("%0t: result with none owed: status %0d phys %h",
                     $time, rsp_data.status, rsp_data.phys_out);
            failures++;
         end else begin
            want = table_outcomes.pop_front();
            if (rsp_data.status !== want.status) begin
               $display("%0t: status expected %0d, got %0d",
                        $time, want.status, rsp_data.status);
               failures++;
            end
            if (rsp_data.phys_out !== want.phys_out) begin
               $display("%0t: phys_out expected %h, got %h",
                        $time, want.phys_out, rsp_data.phys_out);
               failures++;
            end
         end
      end
   end

   // Give up if the run hangs.
   initial begin
      #100_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
